// File: rtl/kvcp_pkg.sv
package kvcp_pkg;

    // command framing characters
    localparam logic [7:0] CHAR_READ   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_WRITE  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_END    = 8'h3B;  // ';'
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_POINT  = 8'h2E;  // '.'
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam int TEXT_BYTES = 7;
    localparam int MANT_W     = 24;

    typedef struct packed {
        logic [2:0]  value_decimals;
        logic [24:0] value_mantissa;
        logic [2:0]  key_length;
        logic [55:0] key_text;
    } result_t;

endpackage

// File: rtl/key_value_command_parser.sv
// Channel   | dir | word                      | accepted when
// ----------+-----+---------------------------+-------------------------
// s_        | in  | one received byte         | s_tvalid && s_tready
// m_        | out | one parsed read/write cmd | m_tvalid && m_tready
//
// One byte is taken every cycle while m_ is not stalled: bytes land in an input
// register and are parsed from it into a result register, so a command result
// shows on m_ from the result register once its ';' has passed the input register.
// aresetn (synchronous, active low) returns the parser to waiting for '='/'+'.
// A result held on a stalled m_ side blocks parsing; one more byte then waits
// in the input register before s_tready drops.
module key_value_command_parser #(
    parameter int KEY_CHARS = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [55:0] key_text, [58:56] key_length,
                                   // [83:59] value_mantissa, [86:84] value_decimals
    output logic        m_tuser    // [0] cmd_is_write
);

    localparam int CW = $clog2(KEY_CHARS + 1);
    localparam int IW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int TXT_CHARS = (KEY_CHARS < kvcp_pkg::TEXT_BYTES) ? KEY_CHARS
                                                                  : kvcp_pkg::TEXT_BYTES;
    localparam logic [CW-1:0] KEY_MAX = CW'(KEY_CHARS);

    typedef enum logic [1:0] {PH_WAIT, PH_KEY, PH_VALUE} phase_t;
    typedef enum logic [1:0] {NUM_SPACE, NUM_INT, NUM_FRAC, NUM_DONE} num_t;

    logic                          in_valid_reg, in_valid_next;
    logic [7:0]                    in_byte_reg, in_byte_next;
    phase_t                        phase_reg, phase_next;
    logic                          write_reg, write_next;
    logic [CW-1:0]                 key_count_reg, key_count_next;
    logic [CW-1:0]                 val_count_reg, val_count_next;
    num_t                          num_reg, num_next;
    logic                          neg_reg, neg_next;
    logic [kvcp_pkg::MANT_W-1:0]   mant_reg, mant_next;
    logic [2:0]                    dec_reg, dec_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_write_reg, out_write_next;
    kvcp_pkg::result_t             out_reg, out_next;
    logic [7:0]                    key_store [KEY_CHARS];

    logic                          step;
    logic                          emit;
    logic                          key_wr;
    logic                          is_blank;
    logic                          is_digit;
    logic [kvcp_pkg::MANT_W-1:0]   mant_x10;
    logic [55:0]                   text;
    logic [24:0]                   mant_signed;
    logic [7:0]                    c;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign c        = in_byte_reg;

    assign is_blank = (c == kvcp_pkg::CHAR_SPACE) ||
                      (c >= kvcp_pkg::CHAR_TAB && c <= kvcp_pkg::CHAR_CR);
    assign is_digit = (c >= kvcp_pkg::CHAR_ZERO && c <= kvcp_pkg::CHAR_NINE);
    // acc*10 + digit, kept to 24 bits
    assign mant_x10 = kvcp_pkg::MANT_W'({mant_reg, 3'b000} + {2'b00, mant_reg, 1'b0}
                                        + {23'd0, c[3:0]});

    always_comb begin
        text = '0;
        for (int i = 0; i < TXT_CHARS; i++) begin
            if (key_count_reg > CW'(i)) begin
                text[8*i +: 8] = key_store[i];
            end
        end
        mant_signed = neg_reg ? (25'd0 - {1'b0, mant_reg}) : {1'b0, mant_reg};
    end

    always_comb begin
        phase_next     = phase_reg;
        write_next     = write_reg;
        key_count_next = key_count_reg;
        val_count_next = val_count_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        mant_next      = mant_reg;
        dec_next       = dec_reg;
        emit           = 1'b0;
        key_wr         = 1'b0;

        if (step) begin
            case (phase_reg)
                PH_WAIT: begin
                    if (c == kvcp_pkg::CHAR_READ || c == kvcp_pkg::CHAR_WRITE) begin
                        write_next = (c == kvcp_pkg::CHAR_WRITE);
                        phase_next = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (c == kvcp_pkg::CHAR_READ) begin
                        if (write_reg) begin
                            phase_next = PH_VALUE;
                        end
                    end else if (c == kvcp_pkg::CHAR_END) begin
                        emit       = 1'b1;
                        phase_next = PH_WAIT;
                    end else if (key_count_reg < KEY_MAX) begin
                        key_wr         = 1'b1;
                        key_count_next = key_count_reg + CW'(1);
                    end
                end
                PH_VALUE: begin
                    if (c == kvcp_pkg::CHAR_END) begin
                        emit       = 1'b1;
                        phase_next = PH_WAIT;
                    end else if (val_count_reg < KEY_MAX) begin
                        val_count_next = val_count_reg + CW'(1);
                        case (num_reg)
                            NUM_SPACE: begin
                                if (is_blank) begin
                                    num_next = NUM_SPACE;
                                end else if (c == kvcp_pkg::CHAR_MINUS ||
                                             c == kvcp_pkg::CHAR_WRITE) begin
                                    neg_next = (c == kvcp_pkg::CHAR_MINUS);
                                    num_next = NUM_INT;
                                end else if (c == kvcp_pkg::CHAR_POINT) begin
                                    num_next = NUM_FRAC;
                                end else if (is_digit) begin
                                    mant_next = kvcp_pkg::MANT_W'(c[3:0]);
                                    num_next  = NUM_INT;
                                end else begin
                                    num_next = NUM_DONE;
                                end
                            end
                            NUM_INT: begin
                                if (is_digit) begin
                                    mant_next = mant_x10;
                                end else if (c == kvcp_pkg::CHAR_POINT) begin
                                    num_next = NUM_FRAC;
                                end else begin
                                    num_next = NUM_DONE;
                                end
                            end
                            NUM_FRAC: begin
                                if (is_digit) begin
                                    mant_next = mant_x10;
                                    dec_next  = dec_reg + 3'd1;
                                end else begin
                                    num_next = NUM_DONE;
                                end
                            end
                            default: begin
                                num_next = num_reg;
                            end
                        endcase
                    end
                end
                default: begin
                    phase_next = PH_WAIT;
                end
            endcase

            // new command or end of command: clear the per-command state
            if ((phase_reg == PH_WAIT && phase_next == PH_KEY) || emit) begin
                key_count_next = '0;
                val_count_next = '0;
                num_next       = NUM_SPACE;
                neg_next       = 1'b0;
                mant_next      = '0;
                dec_next       = '0;
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end else if (step) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_write_next = out_write_reg;
        out_next       = out_reg;
        if (emit) begin
            out_valid_next          = 1'b1;
            out_write_next          = (phase_reg == PH_VALUE);
            out_next.key_text       = text;
            out_next.key_length     = 3'(key_count_reg);
            out_next.value_mantissa = (phase_reg == PH_VALUE) ? mant_signed : 25'd0;
            out_next.value_decimals = (phase_reg == PH_VALUE) ? dec_reg : 3'd0;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_WAIT;
            write_reg     <= 1'b0;
            key_count_reg <= '0;
            val_count_reg <= '0;
            num_reg       <= NUM_SPACE;
            neg_reg       <= 1'b0;
            mant_reg      <= '0;
            dec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            phase_reg     <= phase_next;
            write_reg     <= write_next;
            key_count_reg <= key_count_next;
            val_count_reg <= val_count_next;
            num_reg       <= num_next;
            neg_reg       <= neg_next;
            mant_reg      <= mant_next;
            dec_reg       <= dec_next;
            out_valid_reg <= out_valid_next;
        end
        in_byte_reg   <= in_byte_next;
        out_write_reg <= out_write_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (key_wr) begin
            key_store[key_count_reg[IW-1:0]] <= c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_write_reg;
    assign m_tdata  = {1'b0, out_reg};

`ifndef SYNTH
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (phase_reg == PH_WAIT && key_count_reg == '0 && mant_reg == '0))
        else $error("command state not cleared after result");

    a_read_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[83:59] == 25'd0 && m_tdata[86:84] == 3'd0))
        else $error("read result carries a value");

    a_key_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (key_count_reg <= KEY_MAX && val_count_reg <= KEY_MAX))
        else $error("key or value count past limit");

    a_wait_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WAIT) |-> (num_reg == NUM_SPACE && dec_reg == 3'd0 && !neg_reg))
        else $error("value state live while waiting for command");

    a_value_only_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_VALUE) |-> write_reg)
        else $error("value phase entered on read command");
`endif

endmodule

// File: bench/key_value_command_parser_tb.sv
module key_value_command_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_CHARS    = kvcp_pkg::TEXT_BYTES;
    localparam int RANDOM_WORDS = 1950;
    localparam int HOLD_AT      = 600;   // words sent before the long m_ stall
    localparam int HOLD_CYCLES  = 400;
    localparam int DIR_ROWS     = 27;

    localparam logic [7:0] CHAR_EQ      = kvcp_pkg::CHAR_READ;
    localparam logic [7:0] CHAR_PLUS    = kvcp_pkg::CHAR_WRITE;
    localparam logic [7:0] CHAR_SEMI    = kvcp_pkg::CHAR_END;
    localparam logic [7:0] CHAR_NINE    = kvcp_pkg::CHAR_NINE;
    localparam logic [7:0] CHAR_LOWER_A = "a";
    localparam logic [7:0] CHAR_LOWER_K = "k";
    localparam logic [7:0] CHAR_UNDER   = "_";
    localparam logic [7:0] TAIL_CHARS [6] = '{"e", "x", "i", "n", ".", "-"};

    typedef enum logic [1:0] {P_IDLE, P_KEY, P_VALUE} parse_ph_t;
    typedef enum logic [1:0] {NP_BLANK, NP_INT, NP_FRAC, NP_STOP} number_ph_t;

    typedef struct packed {
        logic              wr;
        kvcp_pkg::result_t res;
    } cmd_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;   // want holds a hand-written result for this word
        cmd_t       want;
    } word_t;

    // directed words; expected results typed in only on the easy ';' rows
    localparam word_t DIRECTED [DIR_ROWS] = '{
        '{8'h00,     1'b0, '0},                            // ignored before a start
        '{CHAR_EQ,   1'b0, '0},
        '{CHAR_SEMI, 1'b1, '{1'b0, '{3'd0, 25'd0, 3'd0, 56'h0}}},
        '{CHAR_EQ,   1'b0, '0},
        '{8'hFF,     1'b0, '0},
        '{CHAR_EQ,   1'b0, '0},                            // '=' in a read key is dropped
        '{CHAR_PLUS, 1'b0, '0},                            // '+' is kept as key text
        '{CHAR_SEMI, 1'b1, '{1'b0, '{3'd0, 25'd0, 3'd2, 56'h2BFF}}},
        '{CHAR_PLUS, 1'b0, '0},
        '{CHAR_SEMI, 1'b1, '{1'b0, '{3'd0, 25'd0, 3'd0, 56'h0}}},   // write cut short
        '{CHAR_PLUS, 1'b0, '0},
        '{CHAR_EQ,   1'b0, '0},
        '{CHAR_NINE, 1'b0, '0},
        '{CHAR_NINE, 1'b0, '0},
        '{CHAR_NINE, 1'b0, '0},
        '{CHAR_NINE, 1'b0, '0},
        '{CHAR_NINE, 1'b0, '0},
        '{CHAR_NINE, 1'b0, '0},
        '{CHAR_NINE, 1'b0, '0},
        '{CHAR_SEMI, 1'b1, '{1'b1, '{3'd0, 25'd9999999, 3'd0, 56'h0}}},
        '{CHAR_PLUS, 1'b0, '0},
        '{CHAR_LOWER_K, 1'b0, '0},
        '{CHAR_EQ,   1'b0, '0},
        '{kvcp_pkg::CHAR_MINUS, 1'b0, '0},
        '{kvcp_pkg::CHAR_POINT, 1'b0, '0},
        '{8'h35,     1'b0, '0},                            // '5'
        '{CHAR_SEMI, 1'b0, '0}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;

    word_t stim_q[$];
    cmd_t  cmd_q[$];
    word_t cur_word;
    int    next_idx   = 0;
    int    words_sent = 0;
    int    err_count  = 0;
    int    hold_left  = 0;
    bit    hold_done  = 1'b0;

    // parser shadow state
    parse_ph_t   ph;
    number_ph_t  num_ph;
    logic        cmd_write;
    logic [7:0]  key_buf [KEY_CHARS];
    int          key_cnt;
    int          val_cnt;
    logic        neg;
    logic [23:0] acc;
    logic [2:0]  dec_acc;

    key_value_command_parser #(
        .KEY_CHARS(KEY_CHARS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_cmd();
        key_cnt = 0;
        val_cnt = 0;
        num_ph  = NP_BLANK;
        neg     = 1'b0;
        acc     = '0;
        dec_acc = '0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] c, output cmd_t r);
        bit digit;
        bit fire;
        digit = (c >= kvcp_pkg::CHAR_ZERO) && (c <= kvcp_pkg::CHAR_NINE);
        fire  = 1'b0;
        r     = '0;
        case (ph)
            P_IDLE: begin
                if (c == kvcp_pkg::CHAR_READ || c == kvcp_pkg::CHAR_WRITE) begin
                    cmd_write = (c == kvcp_pkg::CHAR_WRITE);
                    clear_cmd();
                    ph = P_KEY;
                end
            end
            P_KEY: begin
                if (c == kvcp_pkg::CHAR_READ) begin
                    if (cmd_write)
                        ph = P_VALUE;
                end else if (c == kvcp_pkg::CHAR_END) begin
                    fire = 1'b1;
                end else if (key_cnt < KEY_CHARS) begin
                    key_buf[key_cnt] = c;
                    key_cnt++;
                end
            end
            P_VALUE: begin
                if (c == kvcp_pkg::CHAR_END) begin
                    fire = 1'b1;
                end else if (val_cnt < KEY_CHARS) begin
                    val_cnt++;
                    case (num_ph)
                        NP_BLANK: begin
                            if (c == kvcp_pkg::CHAR_SPACE ||
                                (c >= kvcp_pkg::CHAR_TAB && c <= kvcp_pkg::CHAR_CR)) begin
                                // still in leading white space
                            end else if (c == kvcp_pkg::CHAR_MINUS || c == CHAR_PLUS) begin
                                neg    = (c == kvcp_pkg::CHAR_MINUS);
                                num_ph = NP_INT;
                            end else if (c == kvcp_pkg::CHAR_POINT) begin
                                num_ph = NP_FRAC;
                            end else if (digit) begin
                                acc    = {16'd0, c - kvcp_pkg::CHAR_ZERO};
                                num_ph = NP_INT;
                            end else begin
                                num_ph = NP_STOP;
                            end
                        end
                        NP_INT: begin
                            if (digit)
                                acc = acc * 24'd10 + {16'd0, c - kvcp_pkg::CHAR_ZERO};
                            else if (c == kvcp_pkg::CHAR_POINT)
                                num_ph = NP_FRAC;
                            else
                                num_ph = NP_STOP;
                        end
                        NP_FRAC: begin
                            if (digit) begin
                                acc     = acc * 24'd10 + {16'd0, c - kvcp_pkg::CHAR_ZERO};
                                dec_acc = dec_acc + 3'd1;
                            end else begin
                                num_ph = NP_STOP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ph = P_IDLE;
        endcase
        if (fire) begin
            // a ';' while still in the key is always a read
            r.wr = (ph == P_VALUE);
            for (int i = 0; i < key_cnt; i++)
                r.res.key_text[8*i +: 8] = key_buf[i];
            r.res.key_length = key_cnt[2:0];
            if (r.wr) begin
                r.res.value_mantissa = neg ? -{1'b0, acc} : {1'b0, acc};
                r.res.value_decimals = dec_acc;
            end
            ph = P_IDLE;
            clear_cmd();
        end
        return fire;
    endfunction

    function automatic void add_byte(input logic [7:0] c);
        word_t w;
        w.ch    = c;
        w.typed = 1'b0;
        w.want  = '0;
        stim_q.push_back(w);
    endfunction

    function automatic logic [7:0] key_char(input bit in_write);
        logic [7:0] c;
        case ($urandom_range(9))
            0, 1:    c = 8'($urandom_range(255));
            2:       c = (in_write || $urandom_range(1)) ? CHAR_PLUS : kvcp_pkg::CHAR_READ;
            default: c = 8'(CHAR_LOWER_A + $urandom_range(25));
        endcase
        if (c == kvcp_pkg::CHAR_END || (in_write && c == kvcp_pkg::CHAR_READ))
            c = CHAR_UNDER;
        return c;
    endfunction

    function automatic int idle_pct(input bit sender);
        int third;
        third = stim_q.size() / 3;
        if (words_sent < third)
            return sender ? 33 : 54;
        else if (words_sent < 2 * third)
            return sender ? 54 : 33;
        return 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // sender: offers words, runs the shadow parser on every accepted word
    always @(posedge aclk) begin
        cmd_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (parse_byte(cur_word.ch, r))
                    cmd_q.push_back(cur_word.typed ? cur_word.want : r);
                words_sent <= words_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (next_idx < stim_q.size() && $urandom_range(99) >= idle_pct(1'b1)) begin
                    cur_word <= stim_q[next_idx];
                    s_tdata  <= stim_q[next_idx].ch;
                    s_tvalid <= 1'b1;
                    next_idx++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure plus one long stall to fill the block
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    always @(posedge aclk) begin
        cmd_t              want;
        kvcp_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = kvcp_pkg::result_t'(m_tdata[86:0]);
            if (cmd_q.size() == 0) begin
                report_mismatch("command with none pending, key", {8'd0, got.key_text},
                                64'd0);
            end else begin
                want = cmd_q.pop_front();
                if (m_tuser !== want.wr)
                    report_mismatch("cmd_is_write", {63'd0, m_tuser}, {63'd0, want.wr});
                if (got.key_text !== want.res.key_text)
                    report_mismatch("key_text", {8'd0, got.key_text},
                                    {8'd0, want.res.key_text});
                if (got.key_length !== want.res.key_length)
                    report_mismatch("key_length", {61'd0, got.key_length},
                                    {61'd0, want.res.key_length});
                if (got.value_mantissa !== want.res.value_mantissa)
                    report_mismatch("value_mantissa", {39'd0, got.value_mantissa},
                                    {39'd0, want.res.value_mantissa});
                if (got.value_decimals !== want.res.value_decimals)
                    report_mismatch("value_decimals", {61'd0, got.value_decimals},
                                    {61'd0, want.res.value_decimals});
                if (m_tdata[87] !== 1'b0)
                    report_mismatch("tdata pad bit", {63'd0, m_tdata[87]}, 64'd0);
            end
        end
    end

    initial begin
        int kind;
        int klen;
        int base;
        logic [7:0] b;

        ph        = P_IDLE;
        cmd_write = 1'b0;
        clear_cmd();

        for (int i = 0; i < DIR_ROWS; i++)
            stim_q.push_back(DIRECTED[i]);

        // random commands, mostly well formed
        base = stim_q.size();
        while (stim_q.size() - base < RANDOM_WORDS) begin
            kind = $urandom_range(99);
            klen = ($urandom_range(9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 7);
            if (kind < 8) begin
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
            end else if (kind < 40) begin
                add_byte(kvcp_pkg::CHAR_READ);
                repeat (klen) add_byte(key_char(1'b0));
                add_byte(kvcp_pkg::CHAR_END);
            end else if (kind < 45) begin
                add_byte(kvcp_pkg::CHAR_WRITE);
                repeat (klen) add_byte(key_char(1'b1));
                add_byte(kvcp_pkg::CHAR_END);
            end else begin
                add_byte(kvcp_pkg::CHAR_WRITE);
                repeat (klen) add_byte(key_char(1'b1));
                add_byte(kvcp_pkg::CHAR_READ);
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(1, 9)) begin
                        b = 8'($urandom_range(255));
                        add_byte(b == kvcp_pkg::CHAR_END ? ~kvcp_pkg::CHAR_END : b);
                    end
                end else begin
                    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
                        add_byte($urandom_range(1) ? kvcp_pkg::CHAR_SPACE
                                 : 8'(kvcp_pkg::CHAR_TAB + $urandom_range(4)));
                    case ($urandom_range(3))
                        0: add_byte(kvcp_pkg::CHAR_MINUS);
                        1: add_byte(CHAR_PLUS);
                        default: ;
                    endcase
                    repeat ($urandom_range(0, 7))
                        add_byte(8'(kvcp_pkg::CHAR_ZERO + $urandom_range(9)));
                    if ($urandom_range(1)) begin
                        add_byte(kvcp_pkg::CHAR_POINT);
                        repeat ($urandom_range(0, 6))
                            add_byte(8'(kvcp_pkg::CHAR_ZERO + $urandom_range(9)));
                    end
                    if ($urandom_range(5) == 0)
                        add_byte(TAIL_CHARS[$urandom_range(5)]);
                end
                add_byte(kvcp_pkg::CHAR_END);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_sent < stim_q.size()) @(posedge aclk);
        while (cmd_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5ms;
        $display("[%0t] timeout, %0d commands still pending", $realtime, cmd_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
